### hdl/wsu_pkg.sv
// Package for the wavetable sound unit: transaction types, operation codes,
// RAM geometry and the reciprocal table for the mixer average.
// No dependencies.
package wsu_pkg;

   localparam int RAM_BYTES = 128;
   localparam int RAM_AW    = $clog2(RAM_BYTES);

   localparam logic [3:0]        UPDATE_PERIOD = 4'd15;
   localparam logic [RAM_AW-1:0] COUNT_ADDR    = RAM_AW'(7'h7f);

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_ADDR  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_CTRL  = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic signed [7:0] mix_level;
      logic              level_changed;
   } rsp_type;

   // ceil(2^16 / (code + 1)); exact floor division for magnitudes below 1024
   function automatic logic [16:0] mix_recip(input logic [2:0] code);
      logic [16:0] r;
      case (code)
         3'd0:    r = 17'd65536;
         3'd1:    r = 17'd32768;
         3'd2:    r = 17'd21846;
         3'd3:    r = 17'd16384;
         3'd4:    r = 17'd13108;
         3'd5:    r = 17'd10923;
         3'd6:    r = 17'd9363;
         default: r = 17'd8192;
      endcase
      return r;
   endfunction

endpackage

### hdl/wsu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module wsu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/wavetable_sound_unit.sv
// Eight-voice wavetable sound unit; depends on wsu_pkg and wsu_ram.
// A channel update tick reads the channel's eight registers, steps its phase, fetches the
// wave sample, writes the phase back and then sums the active channels one per cycle to
// form the mixer average; a write to the count byte while enabled also re-averages.
// One transaction at a time; the result register lets the next one start while a result waits.
// Synchronous reset clears control state and the RAM valid bits; unwritten bytes read zero.
module wavetable_sound_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wsu_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wsu_pkg::rsp_type rsp_payload
);

   typedef enum logic [3:0] {
      S_IDLE, S_RD_WAIT, S_CH_RD, S_CH_ADD, S_CH_WRAP, S_CH_WAVE,
      S_CH_SAMP, S_CH_WR3, S_CH_WR1, S_MIX_SUM, S_MIX_MUL, S_MIX_DIV, S_FINISH
   } state_type;

   state_type                    state_ff;
   logic [wsu_pkg::RAM_AW-1:0]   addr_ff;
   logic                         autoinc_ff;
   logic [3:0]                   div_ff;
   logic [2:0]                   chan_ff;
   logic signed [7:0]            level_ff [8];
   logic signed [7:0]            mixer_ff;
   logic                         disabled_ff;
   logic [2:0]                   count_ff;
   logic [wsu_pkg::RAM_BYTES-1:0] valid_ff;
   logic                         rd_valid_ff;
   logic [7:0]                   regs_ff [8];
   logic [3:0]                   idx_ff;
   logic [24:0]                  sum_ff;
   logic [23:0]                  phase_ff;
   logic [7:0]                   pos_ff;
   logic signed [10:0]           acc_ff;
   logic [2:0]                   mix_idx_ff;
   logic                         neg_ff;
   logic [26:0]                  prod_ff;
   logic                         is_tick_ff;
   logic [7:0]                   pend_rd_ff;
   logic                         pend_chg_ff;
   logic                         rsp_valid_ff;
   wsu_pkg::rsp_type             rsp_ff;

   logic                         accept;
   logic                         ram_we;
   logic [wsu_pkg::RAM_AW-1:0]   ram_waddr;
   logic [7:0]                   ram_wdata;
   logic [wsu_pkg::RAM_AW-1:0]   ram_raddr;
   logic [7:0]                   ram_rdata;
   logic [7:0]                   ram_byte;
   logic [wsu_pkg::RAM_AW-1:0]   addr_in;
   logic [4:0]                   div_in;
   logic [3:0]                   idx_m1;
   logic [23:0]                  ch_phase;
   logic [24:0]                  ch_freq;
   logic [8:0]                   lim_hi;
   logic [24:0]                  limit;
   logic [24:0]                  wrapped;
   logic [7:0]                   pos_in;
   logic [3:0]                   samp;
   logic signed [4:0]            sdiff;
   logic signed [9:0]            lvl_prod;
   logic signed [7:0]            lvl_sel;
   logic [10:0]                  mag_full;
   logic [9:0]                   quot;
   logic [9:0]                   quot_s;
   logic [7:0]                   mix_in;
   logic [2:0]                   chan_dn;
   logic [2:0]                   chan_in;

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign ram_byte = rd_valid_ff ? ram_rdata : 8'd0;
   assign addr_in  = autoinc_ff ? addr_ff + wsu_pkg::RAM_AW'(1) : addr_ff;
   assign div_in   = {1'b0, div_ff} + 5'd1;
   assign idx_m1   = idx_ff - 4'd1;

   assign ch_phase = {regs_ff[5], regs_ff[3], regs_ff[1]};
   assign ch_freq  = {7'd0, regs_ff[4][1:0], regs_ff[2], regs_ff[0]};
   assign lim_hi   = 9'd256 - {1'b0, regs_ff[4][7:2], 2'b00};
   assign limit    = {lim_hi, 16'd0};
   assign wrapped  = (sum_ff >= limit) ? sum_ff - limit : sum_ff;
   assign pos_in   = phase_ff[23:16] + regs_ff[6];

   assign samp     = pos_ff[0] ? ram_byte[7:4] : ram_byte[3:0];
   assign sdiff    = $signed({1'b0, samp}) - 5'sd8;
   assign lvl_prod = sdiff * $signed({1'b0, regs_ff[7][3:0]});

   assign lvl_sel  = level_ff[mix_idx_ff];
   assign mag_full = acc_ff[10] ? 11'(-acc_ff) : acc_ff;
   assign quot     = prod_ff[25:16];
   assign quot_s   = neg_ff ? 10'd0 - quot : quot;
   assign mix_in   = quot_s[7:0];

   assign chan_dn  = chan_ff - 3'd1;
   assign chan_in  = (chan_ff == 3'd0 || chan_dn < ~count_ff) ? 3'd7 : chan_dn;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = req_payload.data;
      ram_raddr = addr_ff;
      case (state_ff)
         S_IDLE: begin
            ram_we = accept && (req_payload.operation == wsu_pkg::OP_WRITE);
         end
         S_CH_RD: begin
            ram_raddr = {1'b1, chan_ff, idx_ff[2:0]};
         end
         S_CH_WAVE: begin
            ram_raddr = pos_in[7:1];
         end
         S_CH_SAMP: begin
            ram_we    = 1'b1;
            ram_waddr = {1'b1, chan_ff, 3'd5};
            ram_wdata = phase_ff[23:16];
         end
         S_CH_WR3: begin
            ram_we    = 1'b1;
            ram_waddr = {1'b1, chan_ff, 3'd3};
            ram_wdata = phase_ff[15:8];
         end
         S_CH_WR1: begin
            ram_we    = 1'b1;
            ram_waddr = {1'b1, chan_ff, 3'd1};
            ram_wdata = phase_ff[7:0];
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   wsu_ram #(
      .WIDTH(8),
      .DEPTH(wsu_pkg::RAM_BYTES)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[ram_raddr];
      if (ram_we) begin
         valid_ff[ram_waddr] <= 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_rd_ff  <= 8'd0;
               pend_chg_ff <= 1'b0;
               state_ff    <= S_FINISH;
               case (req_payload.operation)
                  wsu_pkg::OP_TICK: begin
                     if (!disabled_ff) begin
                        if (div_in >= {1'b0, wsu_pkg::UPDATE_PERIOD}) begin
                           div_ff   <= 4'd0;
                           idx_ff   <= 4'd0;
                           state_ff <= S_CH_RD;
                        end else begin
                           div_ff <= div_in[3:0];
                        end
                     end
                  end
                  wsu_pkg::OP_ADDR: begin
                     addr_ff    <= req_payload.data[6:0];
                     autoinc_ff <= req_payload.data[7];
                  end
                  wsu_pkg::OP_WRITE: begin
                     addr_ff <= addr_in;
                     if (addr_ff == wsu_pkg::COUNT_ADDR) begin
                        count_ff <= req_payload.data[6:4];
                        if (!disabled_ff) begin
                           mix_idx_ff <= ~req_payload.data[6:4];
                           acc_ff     <= 11'sd0;
                           is_tick_ff <= 1'b0;
                           state_ff   <= S_MIX_SUM;
                        end
                     end
                  end
                  wsu_pkg::OP_READ: begin
                     addr_ff  <= addr_in;
                     state_ff <= S_RD_WAIT;
                  end
                  wsu_pkg::OP_CTRL: begin
                     disabled_ff <= req_payload.data[6];
                     if (!disabled_ff && req_payload.data[6] && mixer_ff != 8'sd0) begin
                        mixer_ff    <= 8'sd0;
                        pend_chg_ff <= 1'b1;
                     end
                  end
                  default: begin
                     pend_rd_ff <= 8'd0;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            pend_rd_ff <= ram_byte;
            state_ff   <= S_FINISH;
         end
         S_CH_RD: begin
            if (idx_ff != 4'd0) begin
               regs_ff[idx_m1[2:0]] <= ram_byte;
            end
            if (idx_ff == 4'd8) begin
               state_ff <= S_CH_ADD;
            end else begin
               idx_ff <= idx_ff + 4'd1;
            end
         end
         S_CH_ADD: begin
            sum_ff   <= {1'b0, ch_phase} + ch_freq;
            state_ff <= S_CH_WRAP;
         end
         S_CH_WRAP: begin
            phase_ff <= wrapped[23:0];
            state_ff <= S_CH_WAVE;
         end
         S_CH_WAVE: begin
            pos_ff   <= pos_in;
            state_ff <= S_CH_SAMP;
         end
         S_CH_SAMP: begin
            level_ff[chan_ff] <= lvl_prod[7:0];
            state_ff          <= S_CH_WR3;
         end
         S_CH_WR3: begin
            state_ff <= S_CH_WR1;
         end
         S_CH_WR1: begin
            mix_idx_ff <= ~count_ff;
            acc_ff     <= 11'sd0;
            is_tick_ff <= 1'b1;
            state_ff   <= S_MIX_SUM;
         end
         S_MIX_SUM: begin
            acc_ff <= acc_ff + $signed({{3{lvl_sel[7]}}, lvl_sel});
            if (mix_idx_ff == 3'd7) begin
               state_ff <= S_MIX_MUL;
            end else begin
               mix_idx_ff <= mix_idx_ff + 3'd1;
            end
         end
         S_MIX_MUL: begin
            neg_ff   <= acc_ff[10];
            prod_ff  <= 27'(mag_full[9:0]) * 27'(wsu_pkg::mix_recip(count_ff));
            state_ff <= S_MIX_DIV;
         end
         S_MIX_DIV: begin
            if (mix_in != mixer_ff) begin
               mixer_ff    <= mix_in;
               pend_chg_ff <= 1'b1;
            end
            if (is_tick_ff) begin
               chan_ff <= chan_in;
            end
            state_ff <= S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_ff          <= 1'b1;
               rsp_ff.read_data      <= pend_rd_ff;
               rsp_ff.mix_level      <= mixer_ff;
               rsp_ff.level_changed  <= pend_chg_ff;
               state_ff              <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase

      if (reset) begin
         state_ff     <= S_IDLE;
         addr_ff      <= '0;
         autoinc_ff   <= 1'b0;
         div_ff       <= 4'd0;
         chan_ff      <= 3'd7;
         mixer_ff     <= 8'sd0;
         disabled_ff  <= 1'b0;
         count_ff     <= 3'd0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            level_ff[i] <= 8'sd0;
         end
      end
   end

endmodule

### bench/tb_wavetable_sound_unit.sv
// Self-checking bench for wavetable_sound_unit: directed and random CPU port traffic,
// with replies checked against a behavioural copy of the sound unit kept here.
// Depends on wsu_pkg and the wavetable_sound_unit RTL only.
`timescale 1ns / 100ps

module tb_wavetable_sound_unit;

   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;
   // per phase: none, sender idle, receiver stalling, both
   localparam logic [3:0][7:0] IDLE_PCT  = {8'd19, 8'd0, 8'd72, 8'd0};
   localparam logic [3:0][7:0] STALL_PCT = {8'd19, 8'd72, 8'd0, 8'd0};

   typedef struct packed {
      logic             drain;
      logic [1:0]       phase;
      wsu_pkg::req_type item;
   } access_type;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   wsu_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   wsu_pkg::rsp_type rsp_payload;

   access_type       cpu_accesses[$];
   wsu_pkg::rsp_type replies_due[$];
   logic [1:0] run_phase   = 2'd0;
   logic [1:0] fill_phase  = 2'd0;
   logic       drain_next  = 1'b0;
   int         req_count   = 0;
   int         rsp_count   = 0;
   int         quiet_cycles = 0;
   int         mismatches  = 0;

   // sound unit state as seen from the CPU port
   logic [7:0] snd_ram [128];
   int         voice_level [8];
   logic [6:0] port_addr    = '0;
   logic       port_inc     = 1'b0;
   logic [3:0] tick_div     = '0;
   logic [2:0] voice        = 3'd7;
   int         mix_now      = 0;
   logic       muted        = 1'b0;
   int         voice_updates = 0;
   int         mix_changes  = 0;

   wavetable_sound_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int active_voices();
      return int'(snd_ram[wsu_pkg::COUNT_ADDR][6:4]) + 1;
   endfunction

   function automatic logic remix();
      int n;
      int sum;
      int nv;
      n   = active_voices();
      sum = 0;
      for (int i = 8 - n; i < 8; i++) sum += voice_level[i];
      nv = sum / n;
      if (nv == mix_now) return 1'b0;
      mix_now = nv;
      mix_changes++;
      return 1'b1;
   endfunction

   function automatic void step_voice(input logic [2:0] ch);
      logic [6:0]  base;
      logic [31:0] freq;
      logic [31:0] phs;
      logic [31:0] limit;
      logic [7:0]  pos;
      logic [7:0]  wb;
      logic [3:0]  nib;
      base  = {1'b1, ch, 3'b000};
      freq  = {14'd0, snd_ram[base + 7'd4][1:0], snd_ram[base + 7'd2], snd_ram[base]};
      phs   = {8'd0, snd_ram[base + 7'd5], snd_ram[base + 7'd3], snd_ram[base + 7'd1]};
      limit = (32'd256 - {24'd0, snd_ram[base + 7'd4] & 8'hfc}) << 16;
      phs   = phs + freq;
      if (phs >= limit) phs = phs - limit;
      phs = phs & 32'h00ff_ffff;
      pos = phs[23:16] + snd_ram[base + 7'd6];
      wb  = snd_ram[pos[7:1]];
      nib = pos[0] ? wb[7:4] : wb[3:0];
      snd_ram[base + 7'd5] = phs[23:16];
      snd_ram[base + 7'd3] = phs[15:8];
      snd_ram[base + 7'd1] = phs[7:0];
      voice_level[ch] = (int'(nib) - 8) * int'(snd_ram[base + 7'd7][3:0]);
      voice_updates++;
   endfunction

   function automatic wsu_pkg::rsp_type advance_sound_unit(input wsu_pkg::req_type r);
      wsu_pkg::rsp_type reply;
      logic [6:0]       a;
      logic             chg;
      logic             was;
      reply = '0;
      chg   = 1'b0;
      case (r.operation)
         wsu_pkg::OP_TICK: begin
            if (!muted) begin
               tick_div = tick_div + 4'd1;
               if (tick_div >= wsu_pkg::UPDATE_PERIOD) begin
                  tick_div = '0;
                  step_voice(voice);
                  chg = remix();
                  if (voice == 3'd0 || int'(voice) - 1 < 8 - active_voices()) voice = 3'd7;
                  else voice = voice - 3'd1;
               end
            end
         end
         wsu_pkg::OP_ADDR: begin
            port_addr = r.data[6:0];
            port_inc  = r.data[7];
         end
         wsu_pkg::OP_WRITE: begin
            a = port_addr;
            snd_ram[a] = r.data;
            if (port_inc) port_addr = port_addr + 7'd1;
            if (a == wsu_pkg::COUNT_ADDR && !muted) chg = remix();
         end
         wsu_pkg::OP_READ: begin
            reply.read_data = snd_ram[port_addr];
            if (port_inc) port_addr = port_addr + 7'd1;
         end
         wsu_pkg::OP_CTRL: begin
            was   = muted;
            muted = r.data[6];
            if (!was && muted && mix_now != 0) begin
               mix_now = 0;
               chg = 1'b1;
               mix_changes++;
            end
         end
         default: ;
      endcase
      reply.mix_level     = mix_now[7:0];
      reply.level_changed = chg;
      return reply;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("reply %0d: %s is %0d, expected %0d", rsp_count, what, got, want);
   endtask

   task automatic add_access(input logic [2:0] op, input logic [7:0] d);
      access_type s;
      s.drain          = drain_next;
      s.phase          = fill_phase;
      s.item.operation = op;
      s.item.data      = d;
      drain_next = 1'b0;
      cpu_accesses.push_back(s);
   endtask

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin : driver
      access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            replies_due.push_back(advance_sound_unit(req_payload));
            req_count++;
         end
         if (!req_valid || !req_stall) begin
            if (cpu_accesses.size() != 0
                && !(cpu_accesses[0].drain && req_count != rsp_count)
                && $urandom_range(99) >= IDLE_PCT[cpu_accesses[0].phase]) begin
               nxt = cpu_accesses.pop_front();
               req_payload <= nxt.item;
               req_valid   <= 1'b1;
               run_phase   <= nxt.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      wsu_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               flag_mismatch("unexpected reply, mix", int'(rsp_payload.mix_level), 0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  flag_mismatch("read_data", int'(rsp_payload.read_data),
                                int'(want.read_data));
               if (rsp_payload.mix_level !== want.mix_level)
                  flag_mismatch("mix_level", int'(rsp_payload.mix_level),
                                int'(want.mix_level));
               if (rsp_payload.level_changed !== want.level_changed)
                  flag_mismatch("level_changed", int'(rsp_payload.level_changed),
                                int'(want.level_changed));
            end
            rsp_count <= rsp_count + 1;
         end
         rsp_stall <= ($urandom_range(99) < STALL_PCT[run_phase]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int          target;
      int          kind;
      logic [2:0]  ch;
      logic [7:0]  d;
      logic        timed_out;
      foreach (snd_ram[i]) snd_ram[i] = 8'h00;
      foreach (voice_level[i]) voice_level[i] = 0;

      // directed: unwritten read, voice 7 at its extremes (its volume byte is also the
      // count byte), address wrap, undefined codes, phase past the limit, mute and unmute
      add_access(wsu_pkg::OP_READ, 8'h00);
      add_access(wsu_pkg::OP_ADDR, 8'hf8);
      repeat (8) add_access(wsu_pkg::OP_WRITE, 8'hff);
      add_access(3'd7, 8'h00);
      add_access(3'd5, 8'hff);
      repeat (15) add_access(wsu_pkg::OP_TICK, 8'h00);
      add_access(wsu_pkg::OP_CTRL, 8'h40);
      add_access(wsu_pkg::OP_TICK, 8'hff);
      add_access(wsu_pkg::OP_CTRL, 8'hbf);

      for (int blk = 0; blk < 8; blk++) begin
         fill_phase = 2'(blk % 4);
         drain_next = 1'b1;
         target = cpu_accesses.size() + 150;
         while (cpu_accesses.size() < target) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
               repeat ($urandom_range(40, 8)) add_access(wsu_pkg::OP_TICK, 8'($urandom));
            end else if (kind < 57) begin
               ch = 3'($urandom_range(7));
               add_access(wsu_pkg::OP_ADDR, {2'b11, ch, 3'b000});
               repeat (8) add_access(wsu_pkg::OP_WRITE, 8'($urandom));
            end else if (kind < 66) begin
               add_access(wsu_pkg::OP_ADDR, {1'b1, 1'b0, 6'($urandom)});
               repeat ($urandom_range(8, 1)) add_access(wsu_pkg::OP_WRITE, 8'($urandom));
            end else if (kind < 72) begin
               add_access(wsu_pkg::OP_ADDR, {1'($urandom), 7'h7f});
               add_access(wsu_pkg::OP_WRITE, 8'($urandom));
            end else if (kind < 82) begin
               add_access(wsu_pkg::OP_ADDR, 8'($urandom));
               repeat ($urandom_range(6, 1)) add_access(wsu_pkg::OP_READ, 8'($urandom));
            end else if (kind < 87) begin
               d = 8'($urandom);
               d[6] = ($urandom_range(99) < 30);
               add_access(wsu_pkg::OP_CTRL, d);
            end else begin
               repeat ($urandom_range(4, 1)) add_access(3'($urandom_range(7)), 8'($urandom));
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (!(cpu_accesses.size() == 0 && !req_valid && req_count == rsp_count)
             && quiet_cycles < QUIET_LIMIT)
         @(negedge clock);

      timed_out = (quiet_cycles >= QUIET_LIMIT);
      if (!timed_out) begin
         repeat (TAIL_CYCLES) @(posedge clock);
         if (replies_due.size() != 0)
            flag_mismatch("replies still outstanding", 0, replies_due.size());
      end
      $display("Run covered %0d CPU transactions and %0d replies in four idling phases,",
               req_count, rsp_count);
      $display("with %0d channel updates and %0d mix level changes.",
               voice_updates, mix_changes);
      if (mismatches == 0 && !timed_out) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
